@@ rtl/rra_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rra_pkg
// Shared types and constants for the round-robin identifier allocator.
// ----------------------------------------------------------------------------
package rra_pkg;

  localparam int MAX_ID    = 2047;
  localparam int ID_W      = 11;
  localparam int CNT_W     = 12;
  localparam int BIT_W     = 5;
  localparam int WORD_W    = 32;
  localparam int WI_W      = ID_W - BIT_W;
  localparam int LAST_WORD = MAX_ID / WORD_W;
  localparam int NUM_WORDS = LAST_WORD + 1;

  // identifiers of the last bitmap word that do not exceed MAX_ID
  localparam logic [WORD_W-1:0] LAST_MASK =
    {WORD_W{1'b1}} >> (WORD_W - 1 - (MAX_ID % WORD_W));

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_QUERY   = 2'd2,
    CMD_RSVD    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_INVALID   = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_CHECK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [1:0]      command;
    logic [ID_W-1:0] port_id;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] result_id;
    logic [1:0]      status;
  } rsp_t;

  typedef struct packed {
    logic    load_item;
    logic    rd_en;
    logic    step_word;
    logic    commit_alloc;
    logic    commit_release;
    logic    res_load;
    status_t res_status;
    logic    res_found;
    logic    out_load;
  } ctrl_t;

  typedef struct packed {
    cmd_t cmd;
    logic full;
    logic id_ok;
    logic bit_set;
    logic free_found;
  } stat_t;

endpackage
`default_nettype wire

@@ rtl/rra_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rra_dpath
// Bitmap memory, word scan, allocation counters and result registers.
// ----------------------------------------------------------------------------
module rra_dpath import rra_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire ctrl_t ctrl,
  input  wire req_t  req,
  output stat_t      stat,
  output rsp_t       rsp
);

  logic [WORD_W-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] row_valid;
  logic [WORD_W-1:0] rd_q;
  logic              rdv_q;

  cmd_t            cmd_q;
  logic [ID_W-1:0] sel_q;
  logic [WI_W-1:0] word_q;
  logic            first_q;
  logic [ID_W-1:0] last_given;
  logic [CNT_W-1:0] used_count;
  logic [ID_W-1:0] res_id;
  status_t         res_status;
  rsp_t            rsp_q;

  logic [ID_W-1:0]   start_id;
  logic [ID_W-1:0]   sel_id;
  logic [WORD_W-1:0] word_data;
  logic [WORD_W-1:0] scan_mask;
  logic [WORD_W-1:0] free_bits;
  logic [BIT_W-1:0]  enc;
  logic [ID_W-1:0]   found_id;
  logic              wr_en;
  logic [WORD_W-1:0] wr_data;

  // next-fit start, wrapping from the top identifier back to one
  assign start_id = (last_given >= ID_W'(MAX_ID)) ? ID_W'(1) : last_given + ID_W'(1);
  assign sel_id   = (cmd_t'(req.command) == CMD_ALLOC) ? start_id : req.port_id;

  // rows never written read as all free
  assign word_data = rdv_q ? rd_q : '0;

  always_comb begin
    scan_mask = first_q ? ({WORD_W{1'b1}} << sel_q[BIT_W-1:0]) : {WORD_W{1'b1}};
    if (word_q == '0) begin
      scan_mask[0] = 1'b0;
    end
    if (word_q == WI_W'(LAST_WORD)) begin
      scan_mask = scan_mask & LAST_MASK;
    end
  end

  assign free_bits = ~word_data & scan_mask;

  // lowest free bit wins
  always_comb begin
    enc = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        enc = BIT_W'(i);
      end
    end
  end

  assign found_id = {word_q, enc};

  assign stat.cmd        = cmd_q;
  assign stat.full       = (used_count >= CNT_W'(MAX_ID));
  assign stat.id_ok      = (sel_q != '0) && (sel_q <= ID_W'(MAX_ID));
  assign stat.bit_set    = word_data[sel_q[BIT_W-1:0]];
  assign stat.free_found = |free_bits;

  assign wr_en = ctrl.commit_alloc | ctrl.commit_release;

  always_comb begin
    if (ctrl.commit_alloc) begin
      wr_data = word_data | (WORD_W'(1) << enc);
    end else begin
      wr_data = word_data & ~(WORD_W'(1) << sel_q[BIT_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[word_q] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_q  <= mem[word_q];
      rdv_q <= row_valid[word_q];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= '0;
      last_given <= '0;
      used_count <= '0;
    end else begin
      if (wr_en) begin
        row_valid[word_q] <= 1'b1;
      end
      if (ctrl.commit_alloc) begin
        last_given <= found_id;
        used_count <= used_count + CNT_W'(1);
      end else if (ctrl.commit_release && (used_count != '0)) begin
        used_count <= used_count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_item) begin
      cmd_q   <= cmd_t'(req.command);
      sel_q   <= sel_id;
      word_q  <= sel_id[ID_W-1:BIT_W];
      first_q <= 1'b1;
    end else if (ctrl.step_word) begin
      word_q  <= (word_q == WI_W'(LAST_WORD)) ? '0 : word_q + WI_W'(1);
      first_q <= 1'b0;
    end
    if (ctrl.res_load) begin
      res_status <= ctrl.res_status;
      res_id     <= ctrl.res_found ? found_id : '0;
    end
    if (ctrl.out_load) begin
      rsp_q.result_id <= res_id;
      rsp_q.status    <= res_status;
    end
  end

  assign rsp = rsp_q;

endmodule
`default_nettype wire

@@ rtl/rra_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rra_ctrl
// Command sequencer: decode, bitmap word reads, scan steps and result hand-off.
// ----------------------------------------------------------------------------
module rra_ctrl import rra_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  req_valid,
  output logic       req_stall,
  output logic       rsp_valid,
  input  wire logic  rsp_stall,
  input  wire stat_t stat,
  output ctrl_t      ctrl
);

  state_t state, state_next;
  logic   rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    ctrl           = '0;
    req_stall      = (state != S_IDLE);
    rsp_valid_next = rsp_valid;
    if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          ctrl.load_item = 1'b1;
          state_next     = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.cmd)
          CMD_ALLOC: begin
            if (stat.full) begin
              ctrl.res_load   = 1'b1;
              ctrl.res_status = ST_FULL;
              state_next      = S_RESP;
            end else begin
              state_next = S_READ;
            end
          end
          CMD_RELEASE, CMD_QUERY: begin
            if (!stat.id_ok) begin
              ctrl.res_load   = 1'b1;
              ctrl.res_status = ST_INVALID;
              state_next      = S_RESP;
            end else begin
              state_next = S_READ;
            end
          end
          default: begin
            ctrl.res_load   = 1'b1;
            ctrl.res_status = ST_INVALID;
            state_next      = S_RESP;
          end
        endcase
      end
      S_READ: begin
        ctrl.rd_en = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.cmd == CMD_ALLOC) begin
          if (stat.free_found) begin
            ctrl.commit_alloc = 1'b1;
            ctrl.res_load     = 1'b1;
            ctrl.res_status   = ST_OK;
            ctrl.res_found    = 1'b1;
            state_next        = S_RESP;
          end else begin
            ctrl.step_word = 1'b1;
            state_next     = S_READ;
          end
        end else begin
          ctrl.res_load   = 1'b1;
          ctrl.res_status = stat.bit_set ? ST_OK : ST_NOT_ALLOC;
          // release clears the mark only when it was set
          ctrl.commit_release = (stat.cmd == CMD_RELEASE) && stat.bit_set;
          state_next      = S_RESP;
        end
      end
      S_RESP: begin
        if (!rsp_valid || !rsp_stall) begin
          ctrl.out_load  = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/round_robin_id_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_id_allocator
// Next-fit identifier allocator over a bitmap of identifiers 1..MAX_ID.
//
//   channel  direction  payload  handshake
//   req      in         req_t    req_valid / req_stall
//   rsp      out        rsp_t    rsp_valid / rsp_stall
//
// one transaction at a time; release and query pass decode, bitmap read, check
// and result load; rejected commands and allocate on a full pool go from decode
// straight to result load; allocate does one read and one check per 32-bit bitmap
// word visited, up to 65 word visits when the scan wraps back to its first word
// reset is immediate: per-row valid flops make unwritten bitmap rows read free
// after each result load the sequencer returns to idle; the next transaction is
// then taken even while a result still waits under rsp_stall
// ----------------------------------------------------------------------------
module round_robin_id_allocator import rra_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  ctrl_t ctrl;
  stat_t stat;

  rra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  rra_dpath u_dpath (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .req  (req),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule
`default_nettype wire

@@ test/round_robin_id_allocator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_id_allocator_tb
// Drives allocate, release and query transactions into the allocator and
// checks every response against a bitmap model of the identifier pool, or
// against the expected value of a fixed directed row. The run covers a
// directed table, a random mix, and a final stretch without idle cycles.
// ----------------------------------------------------------------------------
module round_robin_id_allocator_tb;
  import rra_pkg::*;

  typedef struct {
    req_t item;
    bit   fixed;
    rsp_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // pool model
  bit [MAX_ID:0] id_busy;
  int            recent_id;
  int            busy_count;

  rsp_t pending_results[$];
  int   errors = 0;
  bit   quiet = 1'b0;

  round_robin_id_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int wrap_next(input int id);
    return (id >= MAX_ID) ? 1 : id + 1;
  endfunction

  function automatic rsp_t allocator_step(input req_t r);
    rsp_t o;
    int   probe;
    int   id;
    o.result_id = '0;
    o.status    = ST_OK;
    id = int'(r.port_id);
    case (cmd_t'(r.command))
      CMD_ALLOC: begin
        o.status = ST_FULL;
        if (busy_count < MAX_ID) begin
          probe = wrap_next(recent_id);
          for (int n = 0; n < MAX_ID; n++) begin
            if (!id_busy[probe]) begin
              id_busy[probe] = 1'b1;
              busy_count++;
              recent_id   = probe;
              o.result_id = probe[ID_W-1:0];
              o.status    = ST_OK;
              break;
            end
            probe = wrap_next(probe);
          end
        end
      end
      CMD_RELEASE: begin
        if (id < 1 || id > MAX_ID) begin
          o.status = ST_INVALID;
        end else if (!id_busy[id]) begin
          o.status = ST_NOT_ALLOC;
        end else begin
          id_busy[id] = 1'b0;
          if (busy_count > 0) busy_count--;
        end
      end
      CMD_QUERY: begin
        if (id < 1 || id > MAX_ID) o.status = ST_INVALID;
        else o.status = id_busy[id] ? ST_OK : ST_NOT_ALLOC;
      end
      default: o.status = ST_INVALID;
    endcase
    return o;
  endfunction

  function automatic plan_row_t plan_row(input cmd_t c, input int id, input bit fixed,
                                         input int want_id, input status_t want_st);
    plan_row_t p;
    p.item.command   = c;
    p.item.port_id   = id[ID_W-1:0];
    p.fixed          = fixed;
    p.want.result_id = want_id[ID_W-1:0];
    p.want.status    = want_st;
    return p;
  endfunction

  // random identifier that is currently allocated, if one turns up quickly
  function automatic logic [ID_W-1:0] held_id();
    int id;
    id = $urandom_range(1, MAX_ID);
    for (int n = 0; n < 256; n++) begin
      if (id_busy[id]) return id[ID_W-1:0];
      id = $urandom_range(1, MAX_ID);
    end
    return id[ID_W-1:0];
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   pick;
    pick = $urandom_range(0, 99);
    r.command = CMD_ALLOC;
    r.port_id = ID_W'($urandom_range(0, MAX_ID));
    if (pick < 45) begin
      r.command = CMD_ALLOC;
    end else if (pick < 70) begin
      r.command = CMD_RELEASE;
      r.port_id = held_id();
    end else if (pick < 85) begin
      r.command = CMD_QUERY;
      if (pick < 78) r.port_id = held_id();
    end else if (pick < 93) begin
      r.command = CMD_RELEASE;
    end else if (pick < 97) begin
      r.command = $urandom_range(0, 1) ? CMD_QUERY : CMD_RELEASE;
      r.port_id = '0;
    end else begin
      r.command = CMD_RSVD;
    end
    return r;
  endfunction

  // one request transaction; the expectation is pushed once it is accepted
  task automatic send(input req_t item, input bit fixed, input rsp_t want);
    rsp_t predicted;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!(req_valid && !req_stall));
    predicted = allocator_step(item);
    pending_results.push_back(fixed ? want : predicted);
  endtask

  task automatic send_checked(input req_t item);
    send(item, 1'b0, '0);
  endtask

  initial begin
    plan_row_t plan[$];
    id_busy    = '0;
    recent_id  = 0;
    busy_count = 0;

    plan.push_back(plan_row(CMD_QUERY,   0,      1, 0, ST_INVALID));
    plan.push_back(plan_row(CMD_RELEASE, 0,      1, 0, ST_INVALID));
    plan.push_back(plan_row(CMD_QUERY,   1,      1, 0, ST_NOT_ALLOC));
    plan.push_back(plan_row(CMD_RELEASE, MAX_ID, 1, 0, ST_NOT_ALLOC));
    plan.push_back(plan_row(CMD_RSVD,    0,      1, 0, ST_INVALID));
    plan.push_back(plan_row(CMD_RSVD,    MAX_ID, 1, 0, ST_INVALID));
    plan.push_back(plan_row(CMD_ALLOC,   0,      1, 1, ST_OK));
    plan.push_back(plan_row(CMD_ALLOC,   MAX_ID, 1, 2, ST_OK));
    plan.push_back(plan_row(CMD_QUERY,   1,      1, 0, ST_OK));
    plan.push_back(plan_row(CMD_QUERY,   2,      1, 0, ST_OK));
    plan.push_back(plan_row(CMD_RELEASE, 1,      1, 0, ST_OK));
    plan.push_back(plan_row(CMD_RELEASE, 1,      1, 0, ST_NOT_ALLOC));
    // next-fit: the freed identifier is not reused right away
    plan.push_back(plan_row(CMD_ALLOC,   'h555,  1, 3, ST_OK));
    plan.push_back(plan_row(CMD_QUERY,   1,      1, 0, ST_NOT_ALLOC));
    plan.push_back(plan_row(CMD_QUERY,   MAX_ID, 1, 0, ST_NOT_ALLOC));
    plan.push_back(plan_row(CMD_RELEASE, 2,      1, 0, ST_OK));
    plan.push_back(plan_row(CMD_ALLOC,   'h2AA,  1, 4, ST_OK));
    plan.push_back(plan_row(CMD_QUERY,   'h555,  0, 0, ST_OK));
    plan.push_back(plan_row(CMD_QUERY,   'h2AA,  0, 0, ST_OK));
    plan.push_back(plan_row(CMD_RELEASE, 3,      0, 0, ST_OK));
    plan.push_back(plan_row(CMD_QUERY,   4,      0, 0, ST_OK));
    plan.push_back(plan_row(CMD_RSVD,    'h2AA,  0, 0, ST_OK));

    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send(plan[i].item, plan[i].fixed, plan[i].want);

    repeat (850) send_checked(random_request());

    quiet = 1'b1;
    repeat (150) send_checked(random_request());
    req_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("round_robin_id_allocator_tb: done, clean");
    end else begin
      $display("round_robin_id_allocator_tb: done, errors");
    end
    $finish;
  end

  // response stall in random-length stretches, each one stalled or open at random
  int  stall_left = 0;
  bit  stall_on = 1'b0;
  always @(posedge clk) begin
    if (rst || quiet) begin
      rsp_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_on   = ($urandom_range(0, 2) == 0);
        stall_left = $urandom_range(1, 17);
      end
      stall_left--;
      rsp_stall <= stall_on;
    end
  end

  always @(posedge clk) begin : check_rsp
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected response transaction: expected none, got id %0d status %0d",
                 $time, rsp.result_id, rsp.status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (rsp.result_id !== want.result_id) begin
          $display("%0t: result_id mismatch: expected %0d, got %0d",
                   $time, want.result_id, rsp.result_id);
          errors++;
        end
        if (rsp.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, want.status, rsp.status);
          errors++;
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("round_robin_id_allocator_tb: done, errors");
    $finish;
  end

endmodule
